// ===== src/mlics_pkg.sv =====
// Shared types and constants for the multi-level input classifier and summer.
// Used by the lane, merge and top-level modules; depends on nothing else.
package mlics_pkg;

    localparam int NUM_CH       = 5;
    localparam int CHANNELS_DEF = 5;
    localparam int SAMPLE_W     = 10;
    localparam int CODE_W       = 3;
    localparam int REACT_W      = 8;
    localparam int DELTA_W      = 11;
    localparam int TABLE_W      = 64;
    localparam int CFG_IDX_W    = 4;

    // Signal codes.
    localparam logic [CODE_W-1:0] CODE_NONE           = 3'd0;
    localparam logic [CODE_W-1:0] CODE_LOW_INHIBIT    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_NORMAL_INHIBIT = 3'd2;
    localparam logic [CODE_W-1:0] CODE_HIGH_INHIBIT   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_EXCITE_LO      = 3'd4;
    localparam logic [CODE_W-1:0] CODE_EXCITE_MID     = 3'd5;
    localparam logic [CODE_W-1:0] CODE_EXCITE_HI      = 3'd6;
    localparam logic [CODE_W-1:0] CODE_CHARGE         = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_INHIBIT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_INHIBIT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_INHIBIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXCITE_LO      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXCITE_HI      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXCITE_MID     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE         = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REACTION       = 4'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_inhibit;
        logic [SAMPLE_W-1:0] high_inhibit;
        logic [SAMPLE_W-1:0] normal_inhibit;
        logic [SAMPLE_W-1:0] excite_lo;
        logic [SAMPLE_W-1:0] excite_hi;
        logic [SAMPLE_W-1:0] excite_mid;
        logic [SAMPLE_W-1:0] charge;
    } levels_t;

    typedef struct packed {
        logic [CODE_W-1:0]         code;
        logic                      charge;
        logic signed [REACT_W-1:0] reaction;
    } lane_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0]        delta;
        logic                             charging;
        logic [NUM_CH-1:0][CODE_W-1:0]    codes;
    } result_t;

endpackage

// ===== src/mlics_lane.sv =====
// One channel lane: threshold ladder, repeat suppression and reaction lookup.
// Holds the channel's last reported code. Depends on mlics_pkg.
module mlics_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic [mlics_pkg::SAMPLE_W-1:0]    sample,
    input  mlics_pkg::levels_t                levels,
    input  logic [mlics_pkg::TABLE_W-1:0]     reaction_table,
    output mlics_pkg::lane_t                  result
);

    logic [mlics_pkg::CODE_W-1:0]         prior_reg;
    logic [mlics_pkg::CODE_W-1:0]         raw_code;
    logic [mlics_pkg::CODE_W-1:0]         code_next;
    logic                                 charge_reg;
    logic                                 charge_next;
    logic signed [mlics_pkg::REACT_W-1:0] react_reg;
    logic signed [mlics_pkg::REACT_W-1:0] react_next;

    // First match wins, whatever order the thresholds are in.
    always_comb
    begin
        if (sample > levels.charge)
            raw_code = mlics_pkg::CODE_CHARGE;
        else if (sample > levels.excite_mid)
            raw_code = mlics_pkg::CODE_EXCITE_MID;
        else if (sample > levels.excite_hi)
            raw_code = mlics_pkg::CODE_EXCITE_HI;
        else if (sample > levels.excite_lo)
            raw_code = mlics_pkg::CODE_EXCITE_LO;
        else if (sample > levels.normal_inhibit)
            raw_code = mlics_pkg::CODE_NORMAL_INHIBIT;
        else if (sample > levels.high_inhibit)
            raw_code = mlics_pkg::CODE_HIGH_INHIBIT;
        else if (sample > levels.low_inhibit)
            raw_code = mlics_pkg::CODE_LOW_INHIBIT;
        else
            raw_code = mlics_pkg::CODE_NONE;
    end

    always_comb
    begin
        charge_next = (raw_code == mlics_pkg::CODE_CHARGE);
        code_next   = (raw_code == prior_reg) ? mlics_pkg::CODE_NONE : raw_code;
        if (code_next == mlics_pkg::CODE_CHARGE)
            react_next = '0;
        else
            react_next = reaction_table[{code_next, 3'b000} +: mlics_pkg::REACT_W];
    end

    // The reported code is also the stored code for the next comparison.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prior_reg <= mlics_pkg::CODE_NONE;
        else if (load)
            prior_reg <= code_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            charge_reg <= charge_next;
            react_reg  <= react_next;
        end
    end

    assign result.code     = prior_reg;
    assign result.charge   = charge_reg;
    assign result.reaction = react_reg;

    // A nonzero report can never repeat the previous report.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (prior_reg == mlics_pkg::CODE_NONE || prior_reg != $past(prior_reg)))
        else $error("lane reported the same code twice in a row");

endmodule

// ===== src/mlics_merge.sv =====
// Merge stage: sums the lane reactions, ORs the charge flags, registers the result.
// Depends on mlics_pkg.
module mlics_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  mlics_pkg::lane_t [mlics_pkg::NUM_CH-1:0] lanes,
    output mlics_pkg::result_t                     result
);

    mlics_pkg::result_t result_reg;
    mlics_pkg::result_t result_next;

    always_comb
    begin
        result_next.delta    = '0;
        result_next.charging = 1'b0;
        for (int i = 0; i < mlics_pkg::NUM_CH; i++)
        begin
            result_next.delta = result_next.delta
                + {{(mlics_pkg::DELTA_W - mlics_pkg::REACT_W){lanes[i].reaction[7]}},
                   lanes[i].reaction};
            result_next.charging = result_next.charging | lanes[i].charge;
            result_next.codes[i] = lanes[i].code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result = result_reg;

    // Five signed bytes always stay inside the result's range.
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ($signed(result_next.delta) >= -11'sd640
                  && $signed(result_next.delta) <= 11'sd635))
        else $error("reaction sum out of range");

endmodule

// ===== src/multi_level_input_classifier_summer.sv =====
// A sample is registered in the lane stage and then in the merge stage; result_valid rises
// once the merge stage holds the result, and the result can transfer from there.
// Throughput: one item per cycle while the output side does not stall; each channel's lane
// updates its stored code in the cycle of the transfer, so the next item can follow at once.
// Reset: stored codes clear to no signal, levels clear to zero, the charge level
// goes to 1023 and the reaction table clears to zero. No clearing pass is needed.
module multi_level_input_classifier_summer #(
    parameter int CHANNELS = mlics_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_0,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_1,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_2,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_3,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_4,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [mlics_pkg::DELTA_W-1:0]  potential_delta,
    output logic                                  charging,
    output logic [mlics_pkg::CODE_W-1:0]          code_0,
    output logic [mlics_pkg::CODE_W-1:0]          code_1,
    output logic [mlics_pkg::CODE_W-1:0]          code_2,
    output logic [mlics_pkg::CODE_W-1:0]          code_3,
    output logic [mlics_pkg::CODE_W-1:0]          code_4,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mlics_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlics_pkg::TABLE_W-1:0]         cfg_data
);

    localparam int ACTIVE = (CHANNELS < mlics_pkg::NUM_CH) ? CHANNELS : mlics_pkg::NUM_CH;

    mlics_pkg::levels_t                      levels_reg;
    logic [mlics_pkg::TABLE_W-1:0]           reaction_reg;
    logic                                    lane_valid_reg;
    logic                                    result_valid_reg;
    logic                                    merge_free;
    logic                                    lane_advance;
    logic                                    accept;
    logic [mlics_pkg::NUM_CH-1:0][mlics_pkg::SAMPLE_W-1:0] samples;
    mlics_pkg::lane_t [mlics_pkg::NUM_CH-1:0] lane_res;
    mlics_pkg::result_t                      result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg   <= '{charge: '1, default: '0};
            reaction_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mlics_pkg::REG_LOW_INHIBIT:    levels_reg.low_inhibit    <= cfg_data[9:0];
                mlics_pkg::REG_HIGH_INHIBIT:   levels_reg.high_inhibit   <= cfg_data[9:0];
                mlics_pkg::REG_NORMAL_INHIBIT: levels_reg.normal_inhibit <= cfg_data[9:0];
                mlics_pkg::REG_EXCITE_LO:      levels_reg.excite_lo      <= cfg_data[9:0];
                mlics_pkg::REG_EXCITE_HI:      levels_reg.excite_hi      <= cfg_data[9:0];
                mlics_pkg::REG_EXCITE_MID:     levels_reg.excite_mid     <= cfg_data[9:0];
                mlics_pkg::REG_CHARGE:         levels_reg.charge         <= cfg_data[9:0];
                mlics_pkg::REG_REACTION:       reaction_reg              <= cfg_data;
                default: ;
            endcase
        end
    end

    // Two-stage flow: the lane stage moves on whenever the output register is free.
    assign merge_free   = !result_valid_reg || !result_stall;
    assign lane_advance = lane_valid_reg && merge_free;
    assign sample_stall = lane_valid_reg && !merge_free;
    assign accept       = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                lane_valid_reg <= 1'b1;
            else if (lane_advance)
                lane_valid_reg <= 1'b0;
            if (lane_advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign samples = {sample_4, sample_3, sample_2, sample_1, sample_0};

    for (genvar i = 0; i < mlics_pkg::NUM_CH; i++)
    begin : g_lane
        if (i < ACTIVE)
        begin : g_on
            mlics_lane u_lane (
                .clk            (clk),
                .rst_n          (rst_n),
                .load           (accept),
                .sample         (samples[i]),
                .levels         (levels_reg),
                .reaction_table (reaction_reg),
                .result         (lane_res[i])
            );
        end
        else
        begin : g_off
            assign lane_res[i] = '0;
        end
    end

    mlics_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (lane_advance),
        .lanes  (lane_res),
        .result (result)
    );

    assign result_valid    = result_valid_reg;
    assign potential_delta = result.delta;
    assign charging        = result.charging;
    assign code_0          = result.codes[0];
    assign code_1          = result.codes[1];
    assign code_2          = result.codes[2];
    assign code_3          = result.codes[3];
    assign code_4          = result.codes[4];

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("input stalled while the output side was free");

    a_charge_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (code_0 == mlics_pkg::CODE_CHARGE
                          || code_1 == mlics_pkg::CODE_CHARGE
                          || code_2 == mlics_pkg::CODE_CHARGE
                          || code_3 == mlics_pkg::CODE_CHARGE
                          || code_4 == mlics_pkg::CODE_CHARGE)) |-> charging)
        else $error("charging code reported without the charging flag");

endmodule

// ===== dv/mlics_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the multi-level input classifier and summer. It watches the sample,
// result and register write channels, predicts every result and compares it field by field.
// Depends on mlics_pkg only.
module mlics_checker #(
    parameter int CHANNELS = mlics_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    input  logic                                  sample_stall,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_0,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_1,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_2,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_3,
    input  logic [mlics_pkg::SAMPLE_W-1:0]        sample_4,
    input  logic                                  result_valid,
    input  logic                                  result_stall,
    input  logic signed [mlics_pkg::DELTA_W-1:0]  potential_delta,
    input  logic                                  charging,
    input  logic [mlics_pkg::CODE_W-1:0]          code_0,
    input  logic [mlics_pkg::CODE_W-1:0]          code_1,
    input  logic [mlics_pkg::CODE_W-1:0]          code_2,
    input  logic [mlics_pkg::CODE_W-1:0]          code_3,
    input  logic [mlics_pkg::CODE_W-1:0]          code_4,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [mlics_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlics_pkg::TABLE_W-1:0]         cfg_data,
    output int unsigned                           mismatches,
    output int unsigned                           outstanding,
    output int unsigned                           transfers_in,
    output int unsigned                           results_out,
    output int unsigned                           writes_done,
    output int unsigned                           charge_repeats,
    output logic [2**mlics_pkg::CODE_W-1:0]       codes_mask
);

    mlics_pkg::levels_t                levels;
    logic [mlics_pkg::TABLE_W-1:0]     reaction_word;
    logic [mlics_pkg::CODE_W-1:0]      last_code [mlics_pkg::NUM_CH];
    mlics_pkg::result_t                pending_results [$];
    int unsigned                       fail_n;
    int unsigned                       in_n;
    int unsigned                       out_n;
    int unsigned                       wr_n;
    int unsigned                       repeat_n;
    logic [2**mlics_pkg::CODE_W-1:0]   mask_seen;

    // The ladder is walked in its fixed priority order, whatever the levels hold.
    function automatic logic [mlics_pkg::CODE_W-1:0] grade_sample(
        mlics_pkg::levels_t lv, logic [mlics_pkg::SAMPLE_W-1:0] s);
        if (s > lv.charge)         return mlics_pkg::CODE_CHARGE;
        if (s > lv.excite_mid)     return mlics_pkg::CODE_EXCITE_MID;
        if (s > lv.excite_hi)      return mlics_pkg::CODE_EXCITE_HI;
        if (s > lv.excite_lo)      return mlics_pkg::CODE_EXCITE_LO;
        if (s > lv.normal_inhibit) return mlics_pkg::CODE_NORMAL_INHIBIT;
        if (s > lv.high_inhibit)   return mlics_pkg::CODE_HIGH_INHIBIT;
        if (s > lv.low_inhibit)    return mlics_pkg::CODE_LOW_INHIBIT;
        return mlics_pkg::CODE_NONE;
    endfunction

    function automatic logic signed [mlics_pkg::REACT_W-1:0] code_reaction(
        logic [mlics_pkg::TABLE_W-1:0] word, logic [mlics_pkg::CODE_W-1:0] c);
        if (c == mlics_pkg::CODE_CHARGE) return '0;
        return word[{c, 3'b000} +: mlics_pkg::REACT_W];
    endfunction

    task automatic flag(input string field, input int want, input int got);
        fail_n++;
        $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        mlics_pkg::result_t                                   want;
        logic [mlics_pkg::NUM_CH-1:0][mlics_pkg::SAMPLE_W-1:0] seen_samples;
        logic [mlics_pkg::NUM_CH-1:0][mlics_pkg::CODE_W-1:0]   seen_codes;
        logic [mlics_pkg::CODE_W-1:0]                         grade;
        logic signed [mlics_pkg::DELTA_W-1:0]                 tally;
        if (!rst_n)
        begin
            levels          = '0;
            levels.charge   = '1;
            reaction_word   = '0;
            foreach (last_code[ch]) last_code[ch] = mlics_pkg::CODE_NONE;
            pending_results.delete();
            fail_n          = 0;
            in_n            = 0;
            out_n           = 0;
            wr_n            = 0;
            repeat_n        = 0;
            mask_seen       = '0;
            mismatches     <= 0;
            outstanding    <= 0;
            transfers_in   <= 0;
            results_out    <= 0;
            writes_done    <= 0;
            charge_repeats <= 0;
            codes_mask     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mlics_pkg::REG_LOW_INHIBIT:
                        levels.low_inhibit    = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_HIGH_INHIBIT:
                        levels.high_inhibit   = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_NORMAL_INHIBIT:
                        levels.normal_inhibit = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_EXCITE_LO:
                        levels.excite_lo      = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_EXCITE_HI:
                        levels.excite_hi      = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_EXCITE_MID:
                        levels.excite_mid     = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_CHARGE:
                        levels.charge         = cfg_data[mlics_pkg::SAMPLE_W-1:0];
                    mlics_pkg::REG_REACTION:
                        reaction_word         = cfg_data;
                    default: ;
                endcase
                wr_n++;
            end

            if (sample_valid && !sample_stall)
            begin
                seen_samples = {sample_4, sample_3, sample_2, sample_1, sample_0};
                want  = '0;
                tally = '0;
                for (int ch = 0; ch < mlics_pkg::NUM_CH; ch++)
                begin
                    if (ch < CHANNELS)
                    begin
                        grade = grade_sample(levels, seen_samples[ch]);
                        // Charging is flagged even when the repeated code is muted.
                        if (grade == mlics_pkg::CODE_CHARGE) want.charging = 1'b1;
                        if (grade == last_code[ch])
                        begin
                            if (grade == mlics_pkg::CODE_CHARGE) repeat_n++;
                            grade = mlics_pkg::CODE_NONE;
                        end
                        last_code[ch] = grade;
                        tally = tally + code_reaction(reaction_word, grade);
                        want.codes[ch] = grade;
                    end
                end
                want.delta = tally;
                pending_results.push_back(want);
                in_n++;
            end

            if (result_valid && !result_stall)
            begin
                seen_codes = {code_4, code_3, code_2, code_1, code_0};
                if (pending_results.size() == 0)
                begin
                    fail_n++;
                    $display("%0t: result transfer, expected none, got delta %0d",
                             $time, potential_delta);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (potential_delta !== want.delta)
                        flag("potential_delta", $signed(want.delta), potential_delta);
                    if (charging !== want.charging)
                        flag("charging", want.charging, charging);
                    for (int ch = 0; ch < mlics_pkg::NUM_CH; ch++)
                    begin
                        if (seen_codes[ch] !== want.codes[ch])
                            flag($sformatf("code_%0d", ch), want.codes[ch], seen_codes[ch]);
                        mask_seen[want.codes[ch]] = 1'b1;
                    end
                end
                out_n++;
            end

            mismatches     <= fail_n;
            outstanding    <= pending_results.size();
            transfers_in   <= in_n;
            results_out    <= out_n;
            writes_done    <= wr_n;
            charge_repeats <= repeat_n;
            codes_mask     <= mask_seen;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Regression top for the multi-level input classifier and summer: clock, reset, stimulus,
// back-pressure and the verdict. Depends on mlics_pkg, the block and mlics_checker.
module tb_top;

    localparam int CLK_PERIOD     = 8;
    localparam int SAMPLE_MAX     = 2**mlics_pkg::SAMPLE_W - 1;
    localparam int LEVEL_REGS     = 7;
    localparam int RUNG_SEL_W     = $clog2(LEVEL_REGS);
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 50;
    localparam int PRESSURE_PHASE = 2;
    localparam int STEADY_PHASE   = 3;
    localparam int QUIET_PHASE    = 6;
    localparam int FLOOR_PHASE    = 7;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 8;
    localparam int CYCLE_LIMIT    = 300000;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 sample_valid = 1'b0;
    logic [mlics_pkg::SAMPLE_W-1:0]       sample_0     = '0;
    logic [mlics_pkg::SAMPLE_W-1:0]       sample_1     = '0;
    logic [mlics_pkg::SAMPLE_W-1:0]       sample_2     = '0;
    logic [mlics_pkg::SAMPLE_W-1:0]       sample_3     = '0;
    logic [mlics_pkg::SAMPLE_W-1:0]       sample_4     = '0;
    logic                                 result_stall = 1'b0;
    logic                                 cfg_valid    = 1'b0;
    logic [mlics_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
    logic [mlics_pkg::TABLE_W-1:0]        cfg_data     = '0;
    logic                                 sample_stall;
    logic                                 result_valid;
    logic signed [mlics_pkg::DELTA_W-1:0] potential_delta;
    logic                                 charging;
    logic [mlics_pkg::CODE_W-1:0]         code_0;
    logic [mlics_pkg::CODE_W-1:0]         code_1;
    logic [mlics_pkg::CODE_W-1:0]         code_2;
    logic [mlics_pkg::CODE_W-1:0]         code_3;
    logic [mlics_pkg::CODE_W-1:0]         code_4;
    logic                                 cfg_ready;

    int unsigned                          mismatches;
    int unsigned                          outstanding;
    int unsigned                          transfers_in;
    int unsigned                          results_out;
    int unsigned                          writes_done;
    int unsigned                          charge_repeats;
    logic [2**mlics_pkg::CODE_W-1:0]      codes_mask;

    int unsigned                          cycles       = 0;
    int unsigned                          hold_asks    = 0;
    int unsigned                          holds_served = 0;
    logic                                 rx_random    = 1'b1;
    logic [mlics_pkg::SAMPLE_W-1:0]       rung [LEVEL_REGS];
    logic [mlics_pkg::SAMPLE_W-1:0]       next_set [mlics_pkg::NUM_CH];

    multi_level_input_classifier_summer #(
        .CHANNELS(mlics_pkg::CHANNELS_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_0(sample_0),
        .sample_1(sample_1),
        .sample_2(sample_2),
        .sample_3(sample_3),
        .sample_4(sample_4),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .potential_delta(potential_delta),
        .charging(charging),
        .code_0(code_0),
        .code_1(code_1),
        .code_2(code_2),
        .code_3(code_3),
        .code_4(code_4),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    mlics_checker #(
        .CHANNELS(mlics_pkg::CHANNELS_DEF)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_0(sample_0),
        .sample_1(sample_1),
        .sample_2(sample_2),
        .sample_3(sample_3),
        .sample_4(sample_4),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .potential_delta(potential_delta),
        .charging(charging),
        .code_0(code_0),
        .code_1(code_1),
        .code_2(code_2),
        .code_3(code_3),
        .code_4(code_4),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .transfers_in(transfers_in),
        .results_out(results_out),
        .writes_done(writes_done),
        .charge_repeats(charge_repeats),
        .codes_mask(codes_mask)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) cycles <= cycles + 1;

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls unless rx_random is low, plus one long hold whenever the stimulus asks for it.
    always
    begin : result_sink
        int unsigned pick;
        int unsigned span;
        @(posedge clk);
        if (hold_asks != holds_served)
        begin
            result_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            holds_served++;
            result_stall <= 1'b0;
        end
        else if (!rx_random)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                result_stall <= 1'b0;
                span = $urandom_range(1, 8);
            end
            else if (pick < 95)
            begin
                result_stall <= 1'b1;
                span = $urandom_range(1, 3);
            end
            else
            begin
                result_stall <= 1'b1;
                span = $urandom_range(10, 40);
            end
            repeat (span - 1) @(posedge clk);
        end
    end

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic cfg_write(input logic [mlics_pkg::CFG_IDX_W-1:0] index,
                             input logic [mlics_pkg::TABLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // The levels go out with random bits above the level width, which the block must drop.
    task automatic load_settings(input logic [mlics_pkg::TABLE_W-1:0] table_word,
                                 input bit stray);
        logic [mlics_pkg::TABLE_W-1:0] filler;
        settle();
        for (int r = 0; r < LEVEL_REGS; r++)
        begin
            filler = {$urandom, $urandom};
            cfg_write(mlics_pkg::CFG_IDX_W'(int'(mlics_pkg::REG_LOW_INHIBIT) + r),
                      {filler[mlics_pkg::TABLE_W-1:mlics_pkg::SAMPLE_W], rung[r]});
        end
        if (stray)
            cfg_write(mlics_pkg::CFG_IDX_W'(int'(mlics_pkg::REG_REACTION) + 1
                                            + $urandom_range(0, 7)),
                      {$urandom, $urandom});
        cfg_write(mlics_pkg::REG_REACTION, table_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_samples(input logic [mlics_pkg::SAMPLE_W-1:0] s0, s1, s2, s3, s4,
                                 input bit gaps);
        int unsigned pick;
        sample_valid <= 1'b1;
        sample_0     <= s0;
        sample_1     <= s1;
        sample_2     <= s2;
        sample_3     <= s3;
        sample_4     <= s4;
        do @(posedge clk); while (sample_stall);
        pick = $urandom_range(0, 99);
        if (gaps && pick >= 60)
        begin
            sample_valid <= 1'b0;
            if (pick < 92)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(8, 30)) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [mlics_pkg::TABLE_W-1:0] word;
        int unsigned                   pick;
        int                            acc;
        int                            level;
        bit                            gaps;
        logic [RUNG_SEL_W-1:0]         rung_sel;
        foreach (next_set[ch]) next_set[ch] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings straight out of reset: every level at zero, the charge level at the top.
        offer_samples(0, 0, 0, 0, 0, 1'b1);
        offer_samples(1023, 1, 512, 1023, 0, 1'b1);
        offer_samples(1023, 1, 512, 1023, 0, 1'b1);

        // Ordered ladder. Byte 0 is +127 and byte 1 is -128, so both sum extremes are reachable.
        rung = '{100, 200, 300, 400, 500, 600, 900};
        load_settings(64'h5540_7EFF_0181_807F, 1'b0);
        offer_samples(150, 250, 350, 450, 550, 1'b1);
        offer_samples(650, 950, 100, 101, 1023, 1'b1);
        offer_samples(0, 0, 0, 0, 0, 1'b1);
        // Five fresh low inhibits give the lowest sum; the same set again mutes every
        // channel and gives the highest.
        offer_samples(101, 101, 101, 101, 101, 1'b1);
        offer_samples(101, 101, 101, 101, 101, 1'b1);
        // A repeated charge reading is muted but still raises the charging flag.
        offer_samples(1023, 1023, 1023, 1023, 1023, 1'b1);
        offer_samples(1023, 1023, 1023, 1023, 1023, 1'b1);
        offer_samples(100, 200, 300, 400, 500, 1'b1);
        offer_samples(101, 201, 301, 401, 501, 1'b1);
        offer_samples(601, 600, 901, 900, 0, 1'b1);

        // Levels out of order; the priority chain still decides. Every reaction but the charge code's is -1.
        rung = '{600, 500, 400, 300, 700, 200, 1000};
        load_settings('1, 1'b1);
        offer_samples(650, 550, 450, 350, 750, 1'b1);
        offer_samples(250, 150, 1001, 1000, 0, 1'b1);
        offer_samples(250, 150, 1001, 1000, 0, 1'b1);

        // Charge level at zero: any nonzero sample charges.
        rung = '{1023, 1023, 1023, 1023, 1023, 1023, 0};
        load_settings('0, 1'b1);
        offer_samples(0, 1, 0, 1, 1023, 1'b1);
        offer_samples(0, 1, 0, 1, 1023, 1'b1);
        offer_samples(512, 0, 0, 0, 0, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == QUIET_PHASE)
            begin
                foreach (rung[r]) rung[r] = '1;
                word = {8{8'h7F}};
            end
            else if (phase == FLOOR_PHASE)
            begin
                foreach (rung[r]) rung[r] = '0;
                word = {8{8'h80}};
            end
            else
            begin
                // Mostly rising ladders so that every code can come up; now and then any order.
                pick = $urandom_range(0, 9);
                acc  = $urandom_range(0, 150);
                foreach (rung[r])
                begin
                    level   = pick < 7 ? acc : int'($urandom_range(0, SAMPLE_MAX));
                    rung[r] = mlics_pkg::SAMPLE_W'(level > SAMPLE_MAX ? SAMPLE_MAX : level);
                    acc     = acc + int'($urandom_range(1, 150));
                end
                if (pick < 2)
                    rung[LEVEL_REGS-1] = mlics_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                word = {$urandom, $urandom};
            end
            load_settings(word, 1'($urandom_range(0, 1)));
            if (phase == PRESSURE_PHASE) hold_asks <= hold_asks + 1;
            if (phase == STEADY_PHASE) rx_random <= 1'b0;
            gaps = phase != PRESSURE_PHASE && phase != STEADY_PHASE;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // A channel that keeps its level exercises the alternation with no signal.
                foreach (next_set[ch])
                begin
                    pick     = $urandom_range(0, 9);
                    rung_sel = RUNG_SEL_W'($urandom_range(0, LEVEL_REGS - 1));
                    level    = int'(rung[rung_sel]) + int'($urandom_range(0, 2)) - 1;
                    level    = level < 0 ? 0 : (level > SAMPLE_MAX ? SAMPLE_MAX : level);
                    if (pick >= 7)
                        next_set[ch] = mlics_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    else if (pick >= 4)
                        next_set[ch] = mlics_pkg::SAMPLE_W'(level);
                end
                offer_samples(next_set[0], next_set[1], next_set[2], next_set[3], next_set[4],
                              gaps);
            end
            if (phase == STEADY_PHASE) rx_random <= 1'b1;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d sample transfers, %0d checked results and %0d register",
                 transfers_in, results_out, writes_done);
        $display("writes in %0d cycles; codes seen, one bit per code: %b; muted charges: %0d.",
                 cycles, codes_mask, charge_repeats);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/mlics_pkg.sv
src/mlics_lane.sv
src/mlics_merge.sv
src/multi_level_input_classifier_summer.sv
dv/mlics_checker.sv
dv/tb_top.sv
